// ===== design/sose_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package sose_pkg;

  localparam int MAX_ELEMS = 8;
  localparam int IDX_W     = (MAX_ELEMS > 1) ? $clog2(MAX_ELEMS) : 1;
  localparam int CNT_W     = $clog2(MAX_ELEMS + 1);
  localparam int VAL_W     = 32;

  localparam int QDEPTH    = 2;
  localparam int QPTR_W    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W    = $clog2(QDEPTH + 1);

  localparam logic [1:0] KIND_LOAD_A = 2'd0;
  localparam logic [1:0] KIND_LOAD_B = 2'd1;
  localparam logic [1:0] KIND_CLEAR  = 2'd2;
  localparam logic [1:0] KIND_RUN    = 2'd3;

  localparam logic [1:0] OPC_UNION   = 2'd0;
  localparam logic [1:0] OPC_INTER   = 2'd1;
  localparam logic [1:0] OPC_DIFF    = 2'd2;
  localparam logic [1:0] OPC_PRODUCT = 2'd3;

  typedef logic signed [VAL_W-1:0] elem_t;
  typedef elem_t set_arr_t [MAX_ELEMS];

  typedef enum logic [1:0] {
    CMD_LOAD_A,
    CMD_LOAD_B,
    CMD_CLEAR,
    CMD_RUN
  } cmd_code_e;

  typedef enum logic [1:0] {
    OP_UNION,
    OP_INTER,
    OP_DIFF,
    OP_PRODUCT
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FIN
  } back_state_e;

  typedef struct packed {
    cmd_code_e code;
    elem_t     value;
    op_e       op;
  } cmd_t;

  typedef struct packed {
    logic             pend_valid;
    logic [CNT_W-1:0] a_count;
    logic [CNT_W-1:0] b_count;
  } back_status_t;

  // Sorted insert with parallel compare and shift; caller checks n < MAX_ELEMS.
  function automatic set_arr_t set_insert(set_arr_t s, logic [CNT_W-1:0] n, elem_t v);
    set_arr_t               r;
    logic [MAX_ELEMS-1:0]   gt;
    for (int p = 0; p < MAX_ELEMS; p++) begin
      gt[p] = (CNT_W'(p) < n) && (s[p] > v);
    end
    r[0] = (gt[0] || n == '0) ? v : s[0];
    for (int p = 1; p < MAX_ELEMS; p++) begin
      if (gt[p-1]) begin
        r[p] = s[p-1];
      end else if (gt[p] || CNT_W'(p) == n) begin
        r[p] = v;
      end else begin
        r[p] = s[p];
      end
    end
    return r;
  endfunction

  function automatic logic in_set(set_arr_t s, logic [CNT_W-1:0] n, elem_t v);
    logic hit;
    hit = 1'b0;
    for (int p = 0; p < MAX_ELEMS; p++) begin
      hit = hit | ((CNT_W'(p) < n) && (s[p] == v));
    end
    return hit;
  endfunction

endpackage
`default_nettype wire

// ===== design/sose_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface sose_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic signed [31:0] value;
  logic [1:0]         operation;

  modport source (output valid, kind, value, operation, input ready);
  modport sink   (input valid, kind, value, operation, output ready);
endinterface

interface sose_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] first_value;
  logic signed [31:0] second_value;
  logic               has_value;
  logic               last;

  modport source (output valid, first_value, second_value, has_value, last, input ready);
  modport sink   (input valid, first_value, second_value, has_value, last, output ready);
endinterface
`default_nettype wire

// ===== design/sose_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module sose_front
  import sose_pkg::*;
(
  sose_in_if.sink   in_ch,
  input  wire logic full,
  output logic      push,
  output cmd_t      cmd
);

  assign in_ch.ready = !full;
  assign push        = in_ch.valid && !full;

  always_comb begin
    cmd.value = in_ch.value;
    case (in_ch.kind)
      KIND_LOAD_A: cmd.code = CMD_LOAD_A;
      KIND_LOAD_B: cmd.code = CMD_LOAD_B;
      KIND_CLEAR:  cmd.code = CMD_CLEAR;
      KIND_RUN:    cmd.code = CMD_RUN;
      default:     cmd.code = CMD_CLEAR;
    endcase
    case (in_ch.operation)
      OPC_UNION:   cmd.op = OP_UNION;
      OPC_INTER:   cmd.op = OP_INTER;
      OPC_DIFF:    cmd.op = OP_DIFF;
      OPC_PRODUCT: cmd.op = OP_PRODUCT;
      default:     cmd.op = OP_UNION;
    endcase
  end

endmodule
`default_nettype wire

// ===== design/sose_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
module sose_queue
  import sose_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  cmd_t      push_data,
  output logic      full,
  input  wire logic pop,
  output cmd_t      head,
  output logic      head_valid
);

  cmd_t              q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign full       = (count == QCNT_W'(QDEPTH));
  assign head_valid = (count != '0);
  assign head       = q[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      q[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== design/sose_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module sose_back
  import sose_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  cmd_t         head,
  input  wire logic    head_valid,
  output logic         pop,
  sose_out_if.source   out_ch,
  output back_status_t status
);

  back_state_e      state;
  back_state_e      state_next;
  set_arr_t         set_a;
  set_arr_t         set_b;
  logic [CNT_W-1:0] a_count;
  logic [CNT_W-1:0] b_count;
  logic [CNT_W-1:0] i_idx;
  logic [CNT_W-1:0] j_idx;
  op_e              run_op;

  logic             pend_valid;
  elem_t            pend_first;
  elem_t            pend_second;

  logic             o_valid;
  elem_t            o_first;
  elem_t            o_second;
  logic             o_has;
  logic             o_last;

  logic             out_free;
  logic             step;
  logic             fin_push;
  logic             run_done;
  logic             a_ok;
  logic             b_ok;
  elem_t            a_rd;
  elem_t            b_rd;
  logic             emit;
  elem_t            emit_first;
  elem_t            emit_second;
  logic             i_inc;
  logic             j_inc;
  logic             j_wrap;
  logic             out_push;

  assign out_free = !o_valid || out_ch.ready;
  assign a_ok     = i_idx < a_count;
  assign b_ok     = j_idx < b_count;
  assign a_rd     = set_a[i_idx[IDX_W-1:0]];
  assign b_rd     = set_b[j_idx[IDX_W-1:0]];

  always_comb begin
    case (run_op)
      OP_UNION:   run_done = !a_ok && !b_ok;
      OP_INTER:   run_done = !a_ok;
      OP_DIFF:    run_done = !a_ok;
      OP_PRODUCT: run_done = !a_ok || (b_count == '0);
      default:    run_done = 1'b1;
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (head_valid && head.code == CMD_RUN) state_next = ST_RUN;
      ST_RUN:  if (out_free && run_done) state_next = ST_FIN;
      ST_FIN:  if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    pop      = 1'b0;
    step     = 1'b0;
    fin_push = 1'b0;
    case (state)
      ST_IDLE: pop      = head_valid;
      ST_RUN:  step     = out_free && !run_done;
      ST_FIN:  fin_push = out_free;
      default: pop      = 1'b0;
    endcase
  end

  // One iteration of the selected operation.
  always_comb begin
    emit        = 1'b0;
    emit_first  = a_rd;
    emit_second = '0;
    i_inc       = 1'b0;
    j_inc       = 1'b0;
    j_wrap      = 1'b0;
    case (run_op)
      OP_UNION: begin
        if (b_ok && in_set(set_a, a_count, b_rd)) begin
          j_inc = 1'b1;
        end else if (!b_ok || (a_ok && a_rd <= b_rd)) begin
          emit  = 1'b1;
          i_inc = 1'b1;
        end else begin
          emit       = 1'b1;
          emit_first = b_rd;
          j_inc      = 1'b1;
        end
      end
      OP_INTER, OP_DIFF: begin
        emit  = in_set(set_b, b_count, a_rd) == (run_op == OP_INTER);
        i_inc = 1'b1;
      end
      OP_PRODUCT: begin
        emit        = 1'b1;
        emit_second = b_rd;
        if ((j_idx + CNT_W'(1)) == b_count) begin
          j_wrap = 1'b1;
          i_inc  = 1'b1;
        end else begin
          j_inc = 1'b1;
        end
      end
      default: emit = 1'b0;
    endcase
  end

  assign out_push = (step && emit && pend_valid) || fin_push;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      a_count    <= '0;
      b_count    <= '0;
      i_idx      <= '0;
      j_idx      <= '0;
      run_op     <= OP_UNION;
      pend_valid <= 1'b0;
      o_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (pop) begin
        case (head.code)
          CMD_LOAD_A: if (a_count < CNT_W'(MAX_ELEMS)) a_count <= a_count + CNT_W'(1);
          CMD_LOAD_B: if (b_count < CNT_W'(MAX_ELEMS)) b_count <= b_count + CNT_W'(1);
          CMD_CLEAR: begin
            a_count <= '0;
            b_count <= '0;
          end
          CMD_RUN: begin
            run_op <= head.op;
            i_idx  <= '0;
            j_idx  <= '0;
          end
          default: a_count <= a_count;
        endcase
      end
      if (step) begin
        if (i_inc) i_idx <= i_idx + CNT_W'(1);
        if (j_wrap) begin
          j_idx <= '0;
        end else if (j_inc) begin
          j_idx <= j_idx + CNT_W'(1);
        end
      end
      if (step && emit) begin
        pend_valid <= 1'b1;
      end else if (fin_push) begin
        pend_valid <= 1'b0;
      end
      if (out_push) begin
        o_valid <= 1'b1;
      end else if (out_ch.ready) begin
        o_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head.code == CMD_LOAD_A && a_count < CNT_W'(MAX_ELEMS)) begin
      set_a <= set_insert(set_a, a_count, head.value);
    end
    if (pop && head.code == CMD_LOAD_B && b_count < CNT_W'(MAX_ELEMS)) begin
      set_b <= set_insert(set_b, b_count, head.value);
    end
    if (step && emit) begin
      pend_first  <= emit_first;
      pend_second <= emit_second;
    end
    if (out_push) begin
      // The final transfer of a run carries the held element, or an empty marker.
      o_first  <= pend_valid ? pend_first : '0;
      o_second <= pend_valid ? pend_second : '0;
      o_has    <= pend_valid;
      o_last   <= fin_push;
    end
  end

  assign out_ch.valid        = o_valid;
  assign out_ch.first_value  = o_first;
  assign out_ch.second_value = o_second;
  assign out_ch.has_value    = o_has;
  assign out_ch.last         = o_last;

  assign status.pend_valid = pend_valid;
  assign status.a_count    = a_count;
  assign status.b_count    = b_count;

endmodule
`default_nettype wire

// ===== design/sorted_set_operation_engine.sv =====
// Sorted set operation engine: two small multisets A and B of signed 32-bit
// values, each kept in ascending order, with union, intersection, difference
// and cartesian product over them.
// in_ch carries kind, value and operation; an item transfers when valid and
// ready are both high. Loads and clears give no result. A run gives one or
// more results on out_ch, last set on the final one; an empty answer gives a
// single result with has_value low.
// Items pass through a two-entry command queue to the execution unit. A run
// makes union na+nb, intersection and difference na, product na*nb iteration
// steps (na, nb the set sizes). Results follow one per cycle while out_ch is
// not stalled, except where union skips a B element found in A or
// intersection/difference drops an element, and the final result is sent
// from the finishing state after the last step. One result is held back until
// the next is known so that last can be set. When out_ch is stalled the
// execution unit holds, the queue fills and in_ch.ready drops. Synchronous
// reset empties both sets, the queue and the output register.
`timescale 1ns / 1ps
`default_nettype none
module sorted_set_operation_engine
  import sose_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  sose_in_if.sink    in_ch,
  sose_out_if.source out_ch
);

  logic         push;
  cmd_t         cmd;
  logic         full;
  logic         pop;
  cmd_t         head;
  logic         head_valid;
  back_status_t status;

  sose_front u_front (
    .in_ch (in_ch),
    .full  (full),
    .push  (push),
    .cmd   (cmd)
  );

  sose_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (cmd),
    .full       (full),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid)
  );

  sose_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .out_ch     (out_ch),
    .status     (status)
  );

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    status.a_count <= CNT_W'(MAX_ELEMS) && status.b_count <= CNT_W'(MAX_ELEMS))
    else $error("set count beyond capacity");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> (status.a_count == $past(status.a_count) ||
              status.a_count == $past(status.a_count) + CNT_W'(1) ||
              status.a_count == '0))
    else $error("set A count changed by more than one insert");

  last_no_pending: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.last |-> !status.pend_valid)
    else $error("element held back behind a final result");

endmodule
`default_nettype wire
